// ----- hdl/assert_macros.svh -----
// assertion macros used by the plt packet indexer core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define PLTIDX_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// boolean condition must never be seen outside reset
`define PLTIDX_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// ----- hdl/pltidx_pkg.sv -----
// types, codes and constants of the plt packet indexer
package pltidx_pkg;

   localparam int unsigned ADDR_W  = 64;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned GC_W    = 4;
   localparam int unsigned CODE_W  = 4;

   localparam logic [GC_W-1:0]    MAX_GROUPS = 4'd10;
   localparam logic [COUNT_W-1:0] TOTAL_PACKETS_RESET = 32'd1;

   // request opcodes
   localparam logic OP_BEGIN    = 1'b0;
   localparam logic OP_PLT_BYTE = 1'b1;

   // result kinds
   localparam logic KIND_PACKET = 1'b0;
   localparam logic KIND_ERROR  = 1'b1;

   // error codes
   localparam logic [CODE_W-1:0] ERR_MID_VALUE      = 4'd0;
   localparam logic [CODE_W-1:0] ERR_TOO_MANY_BYTES = 4'd1;
   localparam logic [CODE_W-1:0] ERR_OVERFLOW       = 4'd2;
   localparam logic [CODE_W-1:0] ERR_ZERO_LENGTH    = 4'd3;
   localparam logic [CODE_W-1:0] ERR_EXCEEDS_DATA   = 4'd4;
   localparam logic [CODE_W-1:0] ERR_ENDS_DISAGREE  = 4'd5;
   localparam logic [CODE_W-1:0] ERR_FINAL_LEAVES   = 4'd6;
   localparam logic [CODE_W-1:0] ERR_NONZERO_PAD    = 4'd7;
   localparam logic [CODE_W-1:0] ERR_DATA_AFTER_FIN = 4'd8;
   localparam logic [CODE_W-1:0] ERR_NO_TILE        = 4'd9;

   // running decoder state; room is the byte count left in the tile-part data
   typedef struct packed {
      logic [ADDR_W-1:0]  length_accum;
      logic [GC_W-1:0]    group_count;
      logic [ADDR_W-1:0]  pkt_cursor;
      logic [ADDR_W-1:0]  data_room;
      logic [COUNT_W-1:0] packets_found;
      logic               tile_open;
      logic               final_seen;
      logic               halted;
   } state_type;

   typedef struct packed {
      logic               kind;
      logic [CODE_W-1:0]  error_code;
      logic [COUNT_W-1:0] packet_number;
      logic [ADDR_W-1:0]  packet_offset;
      logic [ADDR_W-1:0]  packet_length;
      logic               index_complete;
   } result_type;

endpackage

// ----- hdl/pltidx_step.sv -----
// one-request decode step: next state and optional result
module pltidx_step (
   input  pltidx_pkg::state_type  cur,
   input  logic [31:0]            total_packets,
   input  logic                   opcode,
   input  logic [7:0]             plt_byte,
   input  logic                   marker_end,
   input  logic                   tile_plt_end,
   input  logic [63:0]            data_start,
   input  logic [63:0]            data_length,
   output pltidx_pkg::state_type  nxt,
   output logic                   emit,
   output pltidx_pkg::result_type res
);
   import pltidx_pkg::*;

   logic [ADDR_W-1:0]  acc_new;
   logic               plt_closed;
   logic               data_done;
   logic               is_final;
   logic               err;
   logic [CODE_W-1:0]  err_code;

   assign acc_new    = {cur.length_accum[ADDR_W-8:0], plt_byte[6:0]};
   assign plt_closed = marker_end && tile_plt_end;
   assign data_done  = (acc_new == cur.data_room);
   assign is_final   = ((cur.packets_found + 32'd1) == total_packets);

   always_comb begin
      nxt      = cur;
      emit     = 1'b0;
      res      = '0;
      err      = 1'b0;
      err_code = ERR_MID_VALUE;
      if (!cur.halted) begin
         case (opcode)
            OP_BEGIN: begin
               if (cur.tile_open) begin
                  err      = 1'b1;
                  err_code = ERR_ENDS_DISAGREE;
               end else if (cur.final_seen && (data_length != '0)) begin
                  err      = 1'b1;
                  err_code = ERR_DATA_AFTER_FIN;
               end else begin
                  nxt.pkt_cursor   = data_start;
                  nxt.data_room    = data_length;
                  nxt.length_accum = '0;
                  nxt.group_count  = '0;
                  nxt.tile_open    = 1'b1;
               end
            end
            OP_PLT_BYTE: begin
               if (!cur.tile_open) begin
                  err      = 1'b1;
                  err_code = ERR_NO_TILE;
               end else if (cur.group_count >= MAX_GROUPS) begin
                  err      = 1'b1;
                  err_code = ERR_TOO_MANY_BYTES;
               end else if (|cur.length_accum[ADDR_W-1:ADDR_W-7]) begin
                  err      = 1'b1;
                  err_code = ERR_OVERFLOW;
               end else if (plt_byte[7]) begin
                  // continuation byte
                  if (marker_end) begin
                     err      = 1'b1;
                     err_code = ERR_MID_VALUE;
                  end else begin
                     nxt.length_accum = acc_new;
                     nxt.group_count  = cur.group_count + 4'd1;
                  end
               end else begin
                  nxt.length_accum = '0;
                  nxt.group_count  = '0;
                  if (cur.final_seen) begin
                     // padding entries after the final packet
                     if (acc_new != '0) begin
                        err      = 1'b1;
                        err_code = ERR_NONZERO_PAD;
                     end else if (plt_closed) begin
                        nxt.tile_open = 1'b0;
                     end
                  end else if (acc_new == '0) begin
                     err      = 1'b1;
                     err_code = ERR_ZERO_LENGTH;
                  end else if (acc_new > cur.data_room) begin
                     err      = 1'b1;
                     err_code = ERR_EXCEEDS_DATA;
                  end else if (is_final && !data_done) begin
                     err      = 1'b1;
                     err_code = ERR_FINAL_LEAVES;
                  end else if (!is_final && (plt_closed != data_done)) begin
                     err      = 1'b1;
                     err_code = ERR_ENDS_DISAGREE;
                  end else begin
                     emit               = 1'b1;
                     res.kind           = KIND_PACKET;
                     res.packet_number  = cur.packets_found;
                     res.packet_offset  = cur.pkt_cursor;
                     res.packet_length  = acc_new;
                     res.index_complete = is_final;
                     nxt.pkt_cursor     = cur.pkt_cursor + acc_new;
                     nxt.data_room      = cur.data_room - acc_new;
                     nxt.packets_found  = cur.packets_found + 32'd1;
                     if (is_final) begin
                        nxt.final_seen = 1'b1;
                        if (plt_closed) begin
                           nxt.tile_open = 1'b0;
                        end
                     end else if (data_done) begin
                        nxt.tile_open = 1'b0;
                     end
                  end
               end
            end
            default: begin
               nxt = cur;
            end
         endcase
         if (err) begin
            emit           = 1'b1;
            res            = '0;
            res.kind       = KIND_ERROR;
            res.error_code = err_code;
            nxt.halted     = 1'b1;
         end
      end
   end

endmodule

// ----- hdl/plt_packet_indexer_core.sv -----
// top level of the plt packet indexer: request register, decode step, result register
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  opcode, plt byte, marker flags, data window
//   rsp_      out        rsp_valid/rsp_ready  kind, error code, packet number/offset/length
//   csr_      in         csr_wr_en            total packet count, no read-back
//
// one request per cycle unless rsp_ stalls; results go through the result register
// the request register feeds one decode step that updates state and the result register
// the request register advances whenever the result register is empty or being drained;
// a result held on rsp_ stalls the step, and intake stops once the request register is full
// synchronous active-high reset clears decoder state; total_packets returns to 1
`include "assert_macros.svh"

module plt_packet_indexer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_plt_byte,
   input  logic        req_marker_end,
   input  logic        req_tile_plt_end,
   input  logic [63:0] req_data_start,
   input  logic [63:0] req_data_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [3:0]  rsp_error_code,
   output logic [31:0] rsp_packet_number,
   output logic [63:0] rsp_packet_offset,
   output logic [63:0] rsp_packet_length,
   output logic        rsp_index_complete,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import pltidx_pkg::*;

   // configuration
   logic [COUNT_W-1:0] total_packets_ff;

   // request register
   logic              s1_valid_ff;
   logic              s1_opcode_ff;
   logic [7:0]        s1_plt_byte_ff;
   logic              s1_marker_end_ff;
   logic              s1_tile_plt_end_ff;
   logic [ADDR_W-1:0] s1_data_start_ff;
   logic [ADDR_W-1:0] s1_data_length_ff;

   // decoder state and result register
   state_type  st_ff;
   state_type  st_in;
   logic       step_emit;
   result_type step_res;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_ff;

   logic s1_advance;
   logic req_take;

   // the decode step runs when the result register can take its output
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;

   pltidx_step u_step (
      .cur           (st_ff),
      .total_packets (total_packets_ff),
      .opcode        (s1_opcode_ff),
      .plt_byte      (s1_plt_byte_ff),
      .marker_end    (s1_marker_end_ff),
      .tile_plt_end  (s1_tile_plt_end_ff),
      .data_start    (s1_data_start_ff),
      .data_length   (s1_data_length_ff),
      .nxt           (st_in),
      .emit          (step_emit),
      .res           (step_res)
   );

   // result valid: load on a step with output, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (s1_advance && step_emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_packets_ff <= TOTAL_PACKETS_RESET;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         st_ff            <= '0;
      end else begin
         if (csr_wr_en) begin
            total_packets_ff <= csr_wr_data;
         end
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            st_ff <= st_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_opcode_ff       <= req_opcode;
         s1_plt_byte_ff     <= req_plt_byte;
         s1_marker_end_ff   <= req_marker_end;
         s1_tile_plt_end_ff <= req_tile_plt_end;
         s1_data_start_ff   <= req_data_start;
         s1_data_length_ff  <= req_data_length;
      end
      if (s1_advance && step_emit) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_error_code     = rsp_ff.error_code;
   assign rsp_packet_number  = rsp_ff.packet_number;
   assign rsp_packet_offset  = rsp_ff.packet_offset;
   assign rsp_packet_length  = rsp_ff.packet_length;
   assign rsp_index_complete = rsp_ff.index_complete;

   // an error result on the port means the decoder has stopped
   `PLTIDX_ASSERT(a_err_halts, clock, reset,
      (rsp_valid_ff && (rsp_ff.kind == KIND_ERROR)) |-> st_ff.halted, "error without halt")

   // once stopped, a drained result register stays empty
   `PLTIDX_ASSERT(a_halt_silent, clock, reset,
      (st_ff.halted && (!rsp_valid_ff || rsp_ready)) |=> !rsp_valid_ff, "result after halt")

   // group counter never passes the ten-byte limit
   `PLTIDX_NEVER(a_group_limit, clock, reset,
      st_ff.group_count > MAX_GROUPS, "group count over limit")

   // final packet flag only clears through reset
   `PLTIDX_ASSERT(a_final_sticky, clock, reset,
      !$past(reset) |-> !$fell(st_ff.final_seen), "final flag cleared")

endmodule

// ----- tb/plt_packet_indexer_core_test.sv -----
// self-checking testbench for plt_packet_indexer_core: tile-part streams against a packet locator
`timescale 1ns / 1ps

module plt_packet_indexer_core_test;
   import pltidx_pkg::*;

   // one request as it crosses the req_ channel
   typedef struct packed {
      logic        opcode;
      logic [7:0]  plt_byte;
      logic        marker_end;
      logic        tile_plt_end;
      logic [63:0] data_start;
      logic [63:0] data_length;
   } plt_req_type;

   // packet locator: tracks decoder state per accepted request and queues
   // the packet or error record each one should produce
   class index_board_type;
      logic [31:0] total_packets;
      logic [63:0] length_accum;
      logic [3:0]  group_count;
      logic [63:0] pkt_cursor;
      logic [63:0] data_end;
      logic [31:0] packets_found;
      bit          tile_open;
      bit          final_seen;
      bit          halted;
      result_type  awaited_results[$];
      int          mismatches;

      function new();
         total_packets = TOTAL_PACKETS_RESET;
         length_accum  = '0;
         group_count   = '0;
         pkt_cursor    = '0;
         data_end      = '0;
         packets_found = '0;
         tile_open     = 1'b0;
         final_seen    = 1'b0;
         halted        = 1'b0;
         mismatches    = 0;
      endfunction

      function void set_total(input logic [31:0] count);
         total_packets = count;
      endfunction

      // first violation: one error record, then silence until reset
      function bit flag_error(output result_type res, input logic [CODE_W-1:0] code);
         res = '0;
         res.kind = KIND_ERROR;
         res.error_code = code;
         halted = 1'b1;
         return 1'b1;
      endfunction

      function bit locate(input plt_req_type r, output result_type res);
         logic [63:0] value;
         logic [63:0] room;
         logic [31:0] next_count;
         bit          plt_closed;
         bit          data_done;
         bit          is_final;
         res = '0;
         if (halted)
            return 1'b0;
         if (r.opcode == OP_BEGIN) begin
            if (tile_open)
               return flag_error(res, ERR_ENDS_DISAGREE);
            if (final_seen && r.data_length != 0)
               return flag_error(res, ERR_DATA_AFTER_FIN);
            pkt_cursor   = r.data_start;
            data_end     = r.data_start + r.data_length;
            length_accum = '0;
            group_count  = '0;
            tile_open    = 1'b1;
            return 1'b0;
         end
         if (!tile_open)
            return flag_error(res, ERR_NO_TILE);
         if (group_count >= MAX_GROUPS)
            return flag_error(res, ERR_TOO_MANY_BYTES);
         if (length_accum[63:57] != 0)
            return flag_error(res, ERR_OVERFLOW);
         length_accum = {length_accum[56:0], r.plt_byte[6:0]};
         group_count++;
         if (r.plt_byte[7]) begin
            if (r.marker_end)
               return flag_error(res, ERR_MID_VALUE);
            return 1'b0;
         end
         value        = length_accum;
         length_accum = '0;
         group_count  = '0;
         plt_closed   = r.marker_end && r.tile_plt_end;
         // after the final packet only zero padding is legal
         if (final_seen) begin
            if (value != 0)
               return flag_error(res, ERR_NONZERO_PAD);
            if (plt_closed)
               tile_open = 1'b0;
            return 1'b0;
         end
         if (value == 0)
            return flag_error(res, ERR_ZERO_LENGTH);
         room = data_end - pkt_cursor;
         if (value > room)
            return flag_error(res, ERR_EXCEEDS_DATA);
         data_done  = (value == room);
         next_count = packets_found + 32'd1;
         is_final   = (next_count == total_packets);
         if (is_final && !data_done)
            return flag_error(res, ERR_FINAL_LEAVES);
         if (!is_final && plt_closed != data_done)
            return flag_error(res, ERR_ENDS_DISAGREE);
         res.kind           = KIND_PACKET;
         res.packet_number  = packets_found;
         res.packet_offset  = pkt_cursor;
         res.packet_length  = value;
         res.index_complete = is_final;
         pkt_cursor    += value;
         packets_found  = next_count;
         if (is_final) begin
            final_seen = 1'b1;
            if (plt_closed)
               tile_open = 1'b0;
         end else if (data_done) begin
            tile_open = 1'b0;
         end
         return 1'b1;
      endfunction

      function void take_request(input plt_req_type r);
         result_type res;
         if (locate(r, res))
            awaited_results.push_back(res);
      endfunction

      function void match_result(input result_type got);
         result_type want;
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: kind %0d code %0d number %0d offset %h length %h",
                        got.kind, got.error_code, got.packet_number, got.packet_offset,
                        got.packet_length);
            return;
         end
         want = awaited_results.pop_front();
         if (got.kind !== want.kind || got.error_code !== want.error_code ||
             got.packet_number !== want.packet_number ||
             got.packet_offset !== want.packet_offset ||
             got.packet_length !== want.packet_length ||
             got.index_complete !== want.index_complete) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("expected: kind %0d code %0d number %0d offset %h length %h last %0d",
                        want.kind, want.error_code, want.packet_number, want.packet_offset,
                        want.packet_length, want.index_complete);
               $display("actual:   kind %0d code %0d number %0d offset %h length %h last %0d",
                        got.kind, got.error_code, got.packet_number, got.packet_offset,
                        got.packet_length, got.index_complete);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_opcode;
   logic [7:0]  req_plt_byte;
   logic        req_marker_end;
   logic        req_tile_plt_end;
   logic [63:0] req_data_start;
   logic [63:0] req_data_length;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_kind;
   logic [3:0]  rsp_error_code;
   logic [31:0] rsp_packet_number;
   logic [63:0] rsp_packet_offset;
   logic [63:0] rsp_packet_length;
   logic        rsp_index_complete;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   index_board_type board = new();

   // idle caps for each side; zero gives back-to-back stretches
   int req_gap_cap = 6;
   int rsp_gap_cap = 6;
   int sent_count  = 0;

   plt_packet_indexer_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_plt_byte       (req_plt_byte),
      .req_marker_end     (req_marker_end),
      .req_tile_plt_end   (req_tile_plt_end),
      .req_data_start     (req_data_start),
      .req_data_length    (req_data_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_error_code     (rsp_error_code),
      .rsp_packet_number  (rsp_packet_number),
      .rsp_packet_offset  (rsp_packet_offset),
      .rsp_packet_length  (rsp_packet_length),
      .rsp_index_complete (rsp_index_complete),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // hold a request until accepted, after a random idle gap
   task automatic push_request(input plt_req_type r);
      int gap;
      gap = (req_gap_cap == 0) ? 0 : $urandom_range(0, req_gap_cap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= r.opcode;
      req_plt_byte     <= r.plt_byte;
      req_marker_end   <= r.marker_end;
      req_tile_plt_end <= r.tile_plt_end;
      req_data_start   <= r.data_start;
      req_data_length  <= r.data_length;
      do @(posedge clock); while (!(req_valid && req_ready));
      board.take_request(r);
      sent_count++;
   endtask

   // begin event; plt byte and flags are don't-care and get noise
   task automatic send_begin(input logic [63:0] start, input logic [63:0] length);
      plt_req_type r;
      r.opcode       = OP_BEGIN;
      r.plt_byte     = 8'($urandom);
      r.marker_end   = 1'($urandom);
      r.tile_plt_end = 1'($urandom);
      r.data_start   = start;
      r.data_length  = length;
      push_request(r);
   endtask

   // plt byte event; data window fields are don't-care and get noise
   task automatic send_plt(input logic [7:0] b, input bit mend, input bit tend);
      plt_req_type r;
      r.opcode       = OP_PLT_BYTE;
      r.plt_byte     = b;
      r.marker_end   = mend;
      r.tile_plt_end = tend;
      r.data_start   = {$urandom, $urandom};
      r.data_length  = {$urandom, $urandom};
      push_request(r);
   endtask

   // big-endian 7-bit groups, optionally led by zero groups, ten bytes at most;
   // the flags apply to the closing byte only
   task automatic send_value(input logic [63:0] v, input int pad, input bit mend,
                             input bit tend);
      int         g;
      int         count;
      int         i;
      logic [7:0] b;
      g = 1;
      while (g < 10 && (v >> (7 * g)) != 0)
         g++;
      count = (g + pad > 10) ? 10 : g + pad;
      for (i = count - 1; i >= 0; i--) begin
         b[6:0] = 7'(v >> (7 * i));
         b[7]   = (i != 0);
         if (i == 0)
            send_plt(b, mend, tend);
         else
            send_plt(b, 1'b0, 1'($urandom));
      end
   endtask

   // only idle writes: drain results, let the pipe settle, then one write cycle
   task automatic write_total(input logic [31:0] count);
      req_valid <= 1'b0;
      while (board.awaited_results.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      board.set_total(count);
      csr_wr_en   <= 1'b0;
   endtask

   // a well-formed non-final tile-part: lengths sum to the data window,
   // markers split only at value boundaries, last marker closes the tile-part
   task automatic send_random_tile();
      int          n;
      int          k;
      bit          huge_used;
      bit          last;
      bit          mend;
      bit          tend;
      int          pad;
      logic [63:0] v;
      logic [63:0] sum;
      logic [63:0] lens[$];
      n = $urandom_range(1, 6);
      sum = '0;
      huge_used = 1'b0;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(0, 9))
            0: begin
               if (!huge_used)
                  v = ({$urandom, $urandom} >> $urandom_range(1, 40)) | 64'd1;
               else
                  v = $urandom_range(1, 300);
               huge_used = 1'b1;
            end
            1, 2: v = $urandom_range(128, 2000000);
            default: v = $urandom_range(1, 300);
         endcase
         lens.push_back(v);
         sum += v;
      end
      send_begin({$urandom, $urandom}, sum);
      for (k = 0; k < n; k++) begin
         last = (k == n - 1);
         mend = last ? 1'b1 : ($urandom_range(0, 3) == 0);
         tend = last ? 1'b1 : (mend ? 1'b0 : 1'($urandom));
         pad  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
         send_value(lens[k], pad, mend, tend);
      end
   endtask

   // zero padding values; only the last one ends the tile-part's plt data
   task automatic send_padding(input int count);
      int k;
      bit mend;
      for (k = 0; k < count; k++) begin
         if (k == count - 1) begin
            send_value(64'd0, $urandom_range(0, 9), 1'b1, 1'b1);
         end else begin
            mend = 1'($urandom);
            send_value(64'd0, $urandom_range(0, 9), mend, mend ? 1'b0 : 1'($urandom));
         end
      end
   endtask

   // reach the final packet, then padding and empty tile-parts
   task automatic send_final_run();
      int          m;
      int          k;
      int          t;
      bit          mend;
      logic [63:0] v;
      logic [63:0] sum;
      logic [63:0] lens[$];
      m = $urandom_range(1, 3);
      write_total(board.packets_found + 32'(m));
      sum = '0;
      for (k = 0; k < m; k++) begin
         v = $urandom_range(1, 300);
         lens.push_back(v);
         sum += v;
      end
      send_begin({$urandom, $urandom}, sum);
      for (k = 0; k < m - 1; k++) begin
         mend = ($urandom_range(0, 2) == 0);
         send_value(lens[k], 0, mend, mend ? 1'b0 : 1'($urandom));
      end
      // final packet either closes the tile-part or leaves room for padding
      if ($urandom_range(0, 1)) begin
         send_value(lens[m - 1], 0, 1'b1, 1'b1);
      end else begin
         mend = 1'($urandom);
         send_value(lens[m - 1], 0, mend, mend ? 1'b0 : 1'($urandom));
         send_padding($urandom_range(1, 3));
      end
      for (t = $urandom_range(1, 3); t > 0; t--) begin
         send_begin({$urandom, $urandom}, 64'd0);
         send_padding($urandom_range(1, 3));
      end
   endtask

   // one deliberate violation; the block must go silent afterwards
   task automatic provoke_error(input logic [CODE_W-1:0] code);
      int k;
      case (code)
         ERR_MID_VALUE: begin
            send_begin({$urandom, $urandom}, 64'd0);
            send_plt(8'h81, 1'b1, 1'($urandom));
         end
         ERR_TOO_MANY_BYTES: begin
            send_begin({$urandom, $urandom}, 64'd0);
            for (k = 0; k < 11; k++)
               send_plt(8'h80, 1'b0, 1'($urandom));
         end
         ERR_OVERFLOW: begin
            // accumulator reaches 2^57 after nine groups, tenth byte overflows
            send_begin({$urandom, $urandom}, 64'd0);
            send_plt(8'h82, 1'b0, 1'b0);
            for (k = 0; k < 9; k++)
               send_plt(8'h80, 1'b0, 1'($urandom));
         end
         ERR_ZERO_LENGTH: begin
            send_begin({$urandom, $urandom}, 64'd10);
            send_value(64'd0, $urandom_range(0, 2), 1'b1, 1'b1);
         end
         ERR_EXCEEDS_DATA: begin
            send_begin({$urandom, $urandom}, 64'd5);
            send_value(64'd6, 0, 1'b1, 1'b1);
         end
         ERR_ENDS_DISAGREE: begin
            case ($urandom_range(0, 2))
               0: begin
                  // begin while a tile-part is still open
                  send_begin({$urandom, $urandom}, 64'd10);
                  send_begin({$urandom, $urandom}, 64'd10);
               end
               1: begin
                  // plt ends, data does not
                  send_begin({$urandom, $urandom}, 64'd20);
                  send_value(64'd5, 0, 1'b1, 1'b1);
               end
               default: begin
                  // data ends, plt does not
                  send_begin({$urandom, $urandom}, 64'd5);
                  send_value(64'd5, 0, 1'b1, 1'b0);
               end
            endcase
         end
         ERR_FINAL_LEAVES: begin
            write_total(board.packets_found + 32'd1);
            send_begin({$urandom, $urandom}, 64'd40);
            send_value(64'd39, 0, 1'b1, 1'b1);
         end
         ERR_NONZERO_PAD: begin
            send_begin({$urandom, $urandom}, 64'd0);
            send_value(64'd5, 0, 1'b1, 1'b1);
         end
         ERR_DATA_AFTER_FIN: begin
            send_begin({$urandom, $urandom}, 64'($urandom_range(1, 1000)));
         end
         default: begin
            // no tile-part open
            send_plt(8'($urandom), 1'($urandom), 1'($urandom));
         end
      endcase
   endtask

   // result side: random stalls per result, with runs of constant readiness
   initial begin : result_sink
      int gap;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0)
            rsp_gap_cap = (rsp_gap_cap == 0) ? 6 : 0;
         gap = (rsp_gap_cap == 0) ? 0 : $urandom_range(0, rsp_gap_cap);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // compare every accepted result with the oldest expectation
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.kind           = rsp_kind;
         got.error_code     = rsp_error_code;
         got.packet_number  = rsp_packet_number;
         got.packet_offset  = rsp_packet_offset;
         got.packet_length  = rsp_packet_length;
         got.index_complete = rsp_index_complete;
         board.match_result(got);
      end
   end

   initial begin : stimulus
      int              base;
      int              k;
      logic [CODE_W-1:0] fault;
      plt_req_type     r;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_opcode       <= OP_BEGIN;
      req_plt_byte     <= '0;
      req_marker_end   <= 1'b0;
      req_tile_plt_end <= 1'b0;
      req_data_start   <= '0;
      req_data_length  <= '0;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      fault = 4'($urandom_range(ERR_MID_VALUE, ERR_NO_TILE));
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // total of zero: the final packet lies out of reach for the long run
      write_total(32'd0);

      // directed: wrapping data window, one- to three-group lengths,
      // leading zero groups, marker split without tile-part end
      send_begin(64'hFFFF_FFFF_FFFF_FF80, 64'd16640);
      send_value(64'd1, 4, 1'b1, 1'b0);
      send_value(64'd127, 0, 1'b0, 1'b1);
      send_value(64'd128, 0, 1'b1, 1'b0);
      send_value(64'd16384, 0, 1'b1, 1'b1);
      // largest length: ten bytes, all ones
      send_begin(64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_value(64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b1, 1'b1);

      // random well-formed tile-parts, total moved around but never hit
      base = sent_count;
      while (sent_count - base < 560) begin
         req_gap_cap = ($urandom_range(0, 3) == 0) ? 0 : 6;
         if ($urandom_range(0, 14) == 0) begin
            case ($urandom_range(0, 3))
               0: write_total(32'd0);
               1: write_total(32'hFFFF_FFFF);
               2: write_total(board.packets_found);
               default: write_total($urandom | 32'h8000_0000);
            endcase
         end
         send_random_tile();
      end
      write_total(32'hFFFF_FFFF);

      // violations of an open index come before the final packet,
      // the rest after the final packet and its padding
      req_gap_cap = 6;
      if (fault inside {ERR_ZERO_LENGTH, ERR_EXCEEDS_DATA, ERR_ENDS_DISAGREE,
                        ERR_FINAL_LEAVES}) begin
         provoke_error(fault);
      end else begin
         send_final_run();
         provoke_error(fault);
      end

      // noise into a halted block, plus a write it must still take
      for (k = 0; k < 20; k++) begin
         r.opcode       = 1'($urandom);
         r.plt_byte     = 8'($urandom);
         r.marker_end   = 1'($urandom);
         r.tile_plt_end = 1'($urandom);
         r.data_start   = {$urandom, $urandom};
         r.data_length  = {$urandom, $urandom};
         push_request(r);
      end
      write_total($urandom);

      req_valid <= 1'b0;
      while (board.awaited_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.mismatches == 0 && board.awaited_results.size() == 0) begin
         $display("plt_packet_indexer_core verification clean");
      end else begin
         $display("plt_packet_indexer_core verification failed");
      end
      $finish;
   end

   // generous bound, far beyond the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("plt_packet_indexer_core verification failed");
      $finish;
   end

endmodule

// ----- plt_packet_indexer_core.f -----
+incdir+hdl
hdl/pltidx_pkg.sv
hdl/pltidx_step.sv
hdl/plt_packet_indexer_core.sv
tb/plt_packet_indexer_core_test.sv
